// ===== src/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN bit timing calculator package
// Shared constants, types and lookup functions for the bit timing search.
// ----------------------------------------------------------------------------
package cbt_pkg;

  // Search limits.
  localparam int unsigned MaxPrescale = 1024;
  localparam int unsigned LenMax      = 13;
  localparam int unsigned LenMin      = 5;
  localparam int unsigned NumLens     = LenMax - LenMin + 1;
  localparam int unsigned RatioLimit  = MaxPrescale * LenMax;
  localparam int unsigned RatioW      = $clog2(RatioLimit + 1);
  localparam int unsigned ResW        = $clog2(LenMax);
  localparam int unsigned SelW        = $clog2(NumLens);
  localparam int unsigned DivW        = 32;

  // Field widths.
  localparam int unsigned WordW   = 20;
  localparam int unsigned StatusW = 2;

  // Status codes.
  localparam logic [StatusW-1:0] StatusFound = 2'd0;
  localparam logic [StatusW-1:0] StatusNone  = 2'd1;
  localparam logic [StatusW-1:0] StatusBad   = 2'd2;

  // Divider request and response.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
    logic [DivW-1:0] remainder;
  } div_rsp_t;

  // Bit-time length in quanta for a given table index.
  function automatic logic [ResW-1:0] len_of(input logic [SelW-1:0] sel);
    len_of = ResW'(LenMin) + ResW'(sel);
  endfunction

  // Segment and jump width fields for each bit-time length.
  function automatic logic [15:0] seg_word(input logic [SelW-1:0] sel);
    case (sel)
      4'd0:    seg_word = 16'h1100;
      4'd1:    seg_word = 16'h1200;
      4'd2:    seg_word = 16'h2240;
      4'd3:    seg_word = 16'h2340;
      4'd4:    seg_word = 16'h3340;
      4'd5:    seg_word = 16'h3440;
      4'd6:    seg_word = 16'h3540;
      4'd7:    seg_word = 16'h3640;
      4'd8:    seg_word = 16'h3740;
      default: seg_word = 16'h0000;
    endcase
  endfunction

endpackage

// ===== src/cbt_div.sv =====
// ----------------------------------------------------------------------------
// CAN bit timing divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbt_pkg::div_req_t req_i,
  output cbt_pkg::div_rsp_t rsp_o
);
  import cbt_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] dvd_q, dvd_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dsr_q, dsr_d;
  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;

  // One restoring step: shift in the next dividend bit and trial subtract.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    shifted = {rem_q, dvd_q[DivW-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[DivW]) begin
        rem_d = diff[DivW-1:0];
        dvd_d = {dvd_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivW-1:0];
        dvd_d = {dvd_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result shift registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== src/can_bit_timing_calculator.sv =====
// ----------------------------------------------------------------------------
// CAN bit timing calculator
// Finds a prescaler and bit-time length for a module clock and bit rate.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Fields
//  in      | input     | in_valid_i / in_ready_o | source_clock_i, bit_rate_i
//  out     | output    | out_valid_o/out_ready_i | timing_word_o, achieved_rate_o,
//          |           |                         | status_o
//
// An item goes through the input division, the ratio check, the residue setup,
// the search over at most 13312 ratios, one ratio per cycle, and the prescaler
// and achieved-rate divisions. The three divisions share one restoring divider
// giving one bit per cycle. Bad input skips the divisions and the search. Reset
// clears all control state. The next item is accepted once the previous result
// sits in the output register, even while the far side stalls.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  source_clock_i,
  input  logic [31:0]                  bit_rate_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cbt_pkg::WordW-1:0]    timing_word_o,
  output logic [31:0]                  achieved_rate_o,
  output logic [cbt_pkg::StatusW-1:0]  status_o
);
  import cbt_pkg::*;

  localparam int unsigned CntW = $clog2(RatioW);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDivIn  = 3'd1;
  localparam logic [2:0] StCheck  = 3'd2;
  localparam logic [2:0] StInit   = 3'd3;
  localparam logic [2:0] StSearch = 3'd4;
  localparam logic [2:0] StDivPre = 3'd5;
  localparam logic [2:0] StDivAch = 3'd6;
  localparam logic [2:0] StEmit   = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [31:0]        clk_q, clk_d;
  logic               inc_q, inc_d;
  logic [RatioW-1:0]  ratio_q, ratio_d;
  logic [RatioW-1:0]  sh_q, sh_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [ResW-1:0]    res_q [NumLens];
  logic [ResW-1:0]    res_d [NumLens];
  logic [SelW-1:0]    sel_q, sel_d;
  logic [9:0]         pm1_q, pm1_d;
  logic [WordW-1:0]   word_q, word_d;
  logic [31:0]        ach_q, ach_d;
  logic [StatusW-1:0] stat_q, stat_d;
  logic               out_valid_q, out_valid_d;
  logic [WordW-1:0]   out_word_q, out_word_d;
  logic [31:0]        out_ach_q, out_ach_d;
  logic [StatusW-1:0] out_stat_q, out_stat_d;

  logic [DivW:0]      start_ratio;
  logic [NumLens-1:0] hit;
  logic               any_hit;
  logic [SelW-1:0]    hit_sel;
  logic [ResW:0]      dbl;
  logic [9:0]         pre;
  logic               in_fire;

  div_req_t div_req;
  div_rsp_t div_rsp;

  cbt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // Lengths whose running residue is zero divide the current ratio.
  always_comb begin
    any_hit = 1'b0;
    hit_sel = '0;
    for (int i = 0; i < NumLens; i++) begin
      hit[i] = (res_q[i] == '0);
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_sel = SelW'(i);
      end
    end
  end

  // Only the low ten bits of the prescaler minus one reach the timing word.
  assign start_ratio = {1'b0, div_rsp.quotient} + {{DivW{1'b0}}, inc_q};
  assign pre         = div_rsp.quotient[9:0] - 1'b1;

  // Main sequencer.
  always_comb begin
    state_d     = state_q;
    clk_d       = clk_q;
    inc_d       = inc_q;
    ratio_d     = ratio_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    sel_d       = sel_q;
    pm1_d       = pm1_q;
    word_d      = word_q;
    ach_d       = ach_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_ach_d   = out_ach_q;
    out_stat_d  = out_stat_q;
    dbl         = '0;
    div_req     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          clk_d = source_clock_i;
          if (bit_rate_i == '0 || bit_rate_i > source_clock_i) begin
            word_d  = '0;
            ach_d   = '0;
            stat_d  = StatusBad;
            state_d = StEmit;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = source_clock_i;
            div_req.divisor  = bit_rate_i;
            state_d          = StDivIn;
          end
        end
      end
      StDivIn: begin
        // Round the ratio up when the remainder reaches the quotient.
        if (div_rsp.done) begin
          inc_d   = (div_rsp.remainder >= div_rsp.quotient);
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (start_ratio > (DivW + 1)'(RatioLimit)) begin
          word_d  = '0;
          ach_d   = '0;
          stat_d  = StatusNone;
          state_d = StEmit;
        end else begin
          ratio_d = start_ratio[RatioW-1:0];
          sh_d    = start_ratio[RatioW-1:0];
          cnt_d   = '0;
          for (int i = 0; i < NumLens; i++) begin
            res_d[i] = '0;
          end
          state_d = StInit;
        end
      end
      StInit: begin
        // Residues of the start ratio, one ratio bit per cycle, MSB first.
        for (int i = 0; i < NumLens; i++) begin
          dbl = {res_q[i], sh_q[RatioW-1]};
          if (dbl >= {1'b0, len_of(SelW'(i))}) begin
            dbl = dbl - {1'b0, len_of(SelW'(i))};
          end
          res_d[i] = dbl[ResW-1:0];
        end
        sh_d  = {sh_q[RatioW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(RatioW - 1)) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (any_hit) begin
          sel_d            = hit_sel;
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(ratio_q);
          div_req.divisor  = DivW'(len_of(hit_sel));
          state_d          = StDivPre;
        end else if (ratio_q == RatioW'(RatioLimit)) begin
          word_d  = '0;
          ach_d   = '0;
          stat_d  = StatusNone;
          state_d = StEmit;
        end else begin
          // Step to the next ratio and advance every residue.
          ratio_d = ratio_q + 1'b1;
          for (int i = 0; i < NumLens; i++) begin
            if (res_q[i] == len_of(SelW'(i)) - 1'b1) begin
              res_d[i] = '0;
            end else begin
              res_d[i] = res_q[i] + 1'b1;
            end
          end
        end
      end
      StDivPre: begin
        if (div_rsp.done) begin
          pm1_d            = pre;
          div_req.start    = 1'b1;
          div_req.dividend = clk_q;
          div_req.divisor  = DivW'(ratio_q);
          state_d          = StDivAch;
        end
      end
      StDivAch: begin
        // Assemble the timing word from the table and prescaler bits.
        if (div_rsp.done) begin
          word_d  = {pm1_q[9:6], seg_word(sel_q)} | {14'b0, pm1_q[5:0]};
          ach_d   = div_rsp.quotient;
          stat_d  = StatusFound;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_word_d  = word_q;
          out_ach_d   = ach_q;
          out_stat_d  = stat_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    clk_q      <= clk_d;
    inc_q      <= inc_d;
    ratio_q    <= ratio_d;
    sh_q       <= sh_d;
    res_q      <= res_d;
    sel_q      <= sel_d;
    pm1_q      <= pm1_d;
    word_q     <= word_d;
    ach_q      <= ach_d;
    stat_q     <= stat_d;
    out_word_q <= out_word_d;
    out_ach_q  <= out_ach_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o     = out_valid_q;
  assign timing_word_o   = out_word_q;
  assign achieved_rate_o = out_ach_q;
  assign status_o        = out_stat_q;

  // The search never walks past the ratio limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSearch |-> ratio_q <= RatioW'(RatioLimit))
    else $error("search ratio beyond limit");

  // The divider only finishes while the sequencer waits on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StDivIn || state_q == StDivPre || state_q == StDivAch))
    else $error("divider finished outside a division state");

  // Rejected input and items with no solution carry an all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusFound |-> timing_word_o == '0 && achieved_rate_o == '0)
    else $error("failed item carries a non-zero result");

endmodule

// ===== sim/can_bit_timing_calculator_test.sv =====
// ----------------------------------------------------------------------------
// CAN bit timing calculator testbench
// Sends pairs of module clock and bit rate through the valid/ready input
// channel and checks every result against an independent search for the
// prescaler and bit-time length. The run covers bad input, rounding up of the
// clock ratio, every bit-time length, prescalers above the field width and
// ratios either side of the search limit, followed by constrained random
// items. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbt_pkg::*;

  localparam int unsigned RandomItems = 80;
  localparam int unsigned IdlePct     = 12;
  localparam int unsigned StallLimit  = 60000;
  localparam int unsigned DrainCycles = 200;

  // Segment and jump width fields, indexed by bit-time length minus LenMin.
  localparam logic [15:0] SegFields [0:NumLens-1] = '{
    16'h1100, 16'h1200, 16'h2240, 16'h2340, 16'h3340,
    16'h3440, 16'h3540, 16'h3640, 16'h3740
  };

  typedef struct packed {
    logic [WordW-1:0]   word;
    logic [31:0]        rate;
    logic [StatusW-1:0] status;
  } timing_result_t;

  // Holds the expected timings in order and compares each result item.
  class timing_scoreboard;
    timing_result_t expected_q[$];
    int unsigned    mismatches = 0;

    // Walks the clock ratios upward until a bit-time length divides one.
    function timing_result_t search_timing(logic [31:0] clock_hz, logic [31:0] rate_bps);
      timing_result_t  res;
      longint unsigned ratio;
      longint unsigned prescale_m1;
      int unsigned     len;
      bit              found;
      res.word   = '0;
      res.rate   = '0;
      res.status = StatusNone;
      found      = 1'b0;
      if (rate_bps == 0 || rate_bps > clock_hz) begin
        res.status = StatusBad;
        return res;
      end
      ratio = longint'(clock_hz) / longint'(rate_bps);
      if (longint'(clock_hz) / ratio > longint'(rate_bps)) begin
        ratio++;
      end
      while (!found && ratio <= RatioLimit) begin
        for (len = LenMax; len >= LenMin && !found; len--) begin
          if (ratio % len == 0) begin
            prescale_m1 = ratio / len - 1;
            res.word    = WordW'(SegFields[len - LenMin])
                        | WordW'(prescale_m1 & 64'h3F)
                        | WordW'((prescale_m1 << 10) & 64'hF0000);
            res.rate    = 32'(longint'(clock_hz) / ratio);
            res.status  = StatusFound;
            found       = 1'b1;
          end
        end
        ratio++;
      end
      return res;
    endfunction

    function void note_item(logic [31:0] clock_hz, logic [31:0] rate_bps);
      expected_q.push_back(search_timing(clock_hz, rate_bps));
    endfunction

    function void check_result(logic [WordW-1:0] word, logic [31:0] rate,
                               logic [StatusW-1:0] status);
      timing_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result item with nothing expected: word %h rate %0d status %0d",
                 $time, word, rate, status);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (word !== want.word) begin
        $display("%0t: timing_word expected %h actual %h", $time, want.word, word);
        mismatches++;
      end
      if (rate !== want.rate) begin
        $display("%0t: achieved_rate expected %0d actual %0d", $time, want.rate, rate);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [31:0]         source_clock_i = '0;
  logic [31:0]         bit_rate_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [WordW-1:0]    timing_word_o;
  logic [31:0]         achieved_rate_o;
  logic [StatusW-1:0]  status_o;

  timing_scoreboard book = new;
  bit               steady = 1'b0;
  int unsigned      quiet_cycles = 0;

  can_bit_timing_calculator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .source_clock_i  (source_clock_i),
    .bit_rate_i      (bit_rate_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .timing_word_o   (timing_word_o),
    .achieved_rate_o (achieved_rate_o),
    .status_o        (status_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // The receiver stalls at random, except during the steady stretch.
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      book.check_result(timing_word_o, achieved_rate_o, status_o);
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Now and then lowers valid for a random gap. Called at a falling edge.
  task automatic idle_gap();
    if (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
  endtask

  // Offers one item and waits until the block takes it.
  task automatic send_item(logic [31:0] clock_hz, logic [31:0] rate_bps);
    idle_gap();
    in_valid_i     <= 1'b1;
    source_clock_i <= clock_hz;
    bit_rate_i     <= rate_bps;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_item(clock_hz, rate_bps);
    @(negedge clk_i);
  endtask

  // Holds the sender back until every expected result has come.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (book.expected_q.size() != 0);
  endtask

  // Mostly well-formed pairs built from a chosen ratio, plus noise and bad input.
  task automatic make_random_item(output logic [31:0] clock_hz, output logic [31:0] rate_bps);
    int unsigned     pick;
    int unsigned     ratio;
    logic [31:0]     rem;
    longint unsigned total;
    pick = $urandom_range(99);
    if (pick < 12) begin
      if ($urandom_range(1) == 0) begin
        clock_hz = $urandom;
        rate_bps = '0;
      end else begin
        clock_hz = $urandom_range(32'hFFFF_FFFE, 0);
        rate_bps = $urandom_range(32'hFFFF_FFFF, clock_hz + 1);
      end
    end else if (pick < 27) begin
      clock_hz = $urandom;
      rate_bps = $urandom;
    end else begin
      case ($urandom_range(3))
        0: begin
          ratio    = 1;
          rate_bps = $urandom_range(32'hFFFF_FFFF, 1);
        end
        1: begin
          ratio    = $urandom_range(60, 2);
          rate_bps = $urandom_range(32'hFFFF_FFFF / (ratio + 1), 1);
        end
        2: begin
          ratio    = $urandom_range(RatioLimit, 1);
          rate_bps = $urandom_range(300000, 1);
        end
        default: begin
          ratio    = $urandom_range(RatioLimit + 24, RatioLimit - 24);
          rate_bps = $urandom_range(300000, 1);
        end
      endcase
      rem      = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(rate_bps - 1, 0);
      total    = longint'(rate_bps) * ratio + rem;
      clock_hz = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned n;
    logic [31:0] clock_hz;
    logic [31:0] rate_bps;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Bad input: zero rate, and a rate above the clock.
    send_item(32'd0, 32'd0);
    send_item(32'd1000, 32'd0);
    send_item(32'd1000, 32'd1001);
    send_item(32'd0, 32'd1);
    // Ratio of one at the widest values, walking up to the first length.
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Truncated ratio gives too high a rate and is rounded up.
    send_item(32'hFFFF_FFFF, 32'h8000_0000);
    send_item(32'd10999, 32'd1000);
    // Every bit-time length with a prescaler of one.
    for (len = LenMin; len <= LenMax; len++) begin
      send_item(len, 32'd1);
    end
    // Ratios at and just beyond the search limit.
    send_item(RatioLimit, 32'd1);
    send_item(RatioLimit + 1, 32'd1);
    send_item(32'hFFFF_FFFF, 32'd1);
    // Prescalers too wide for the timing word fields.
    send_item(32'd5155000, 32'd1000);
    send_item(32'd13311000, 32'd1000);
    drain();

    // Random items, with a long steady stretch and one full drain.
    for (n = 0; n < RandomItems; n++) begin
      steady = (n >= 30 && n < 70);
      if (n == 75) begin
        drain();
      end
      make_random_item(clock_hz, rate_bps);
      send_item(clock_hz, rate_bps);
    end
    steady = 1'b0;
    drain();
    repeat (DrainCycles) @(posedge clk_i);

    if (book.mismatches == 0 && book.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cbt_pkg.sv
src/cbt_div.sv
src/can_bit_timing_calculator.sv
sim/can_bit_timing_calculator_test.sv
